// ===== src/hpm_pkg.sv =====
// hpm_pkg: types and constants for the performance-monitor counter bank.
// No dependencies.
`default_nettype none
package hpm_pkg;
   localparam int NUM_COUNTERS   = 29;
   localparam int NUM_EVENTS     = 64;
   localparam int INHIBIT_OFFSET = 3;
   localparam int EVT_IDX_W      = 6;

   typedef enum logic [2:0] {
      CMD_LOAD_ID = 3'd0,
      CMD_WR_SEL  = 3'd1,
      CMD_SIGNAL  = 3'd2,
      CMD_TICK    = 3'd3,
      CMD_READ    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_APPLY,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [5:0]  index;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic [63:0] pending_events;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/hpm_event_counter_unit.sv =====
// hpm_event_counter_unit: top level of the performance-monitor counter bank.
// Depends on hpm_pkg.
//
//  channel | ports                     | handshake
//  req     | start, busy, req_payload  | taken when start && !busy
//  rsp     | rsp_valid, rsp_payload    | one-cycle strobe, no backpressure
//  csr     | csr_valid, csr_ready, csr_data | write when valid && ready
//
// Non-tick commands go from acceptance through the response state to the result beat.
// A tick walks every event slot in order, sharing one id memory read: a
// pending event passes FETCH (id memory read), then APPLY (a parallel
// compare against all selectors and increment); a non-pending event
// passes FETCH only.
// Synchronous reset clears control, counters, selectors and event ids are
// kept in valid-bit form (event id table valid bits cleared by reset).
// busy is high from acceptance until the result beat; the receiver cannot stall.
`default_nettype none
module hpm_event_counter_unit
   import hpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   output rsp_type      rsp_payload,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [31:0] csr_data
);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [EVT_IDX_W-1:0] evt_ff, evt_in;
   logic [63:0] pend_ff;
   logic [31:0] inhibit_ff;
   logic [63:0] id_mem [NUM_EVENTS];
   logic [NUM_EVENTS-1:0] id_vld_ff;
   logic [63:0] id_rd_ff;
   logic        id_rd_vld_ff;
   logic [63:0] sel_ff [NUM_COUNTERS];
   logic [63:0] cnt_ff [NUM_COUNTERS];
   logic [63:0] rd_data_ff;
   logic        walk_last;

   assign csr_ready = (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign walk_last = (evt_ff == EVT_IDX_W'(NUM_EVENTS - 1));

   // sequencer
   always_comb begin
      state_in = state_ff;
      evt_in   = evt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            evt_in = '0;
            if (start) begin
               state_in = (req_payload.cmd == CMD_TICK) ? ST_FETCH : ST_RESP;
            end
         end
         ST_FETCH: begin
            if (pend_ff[evt_ff]) begin
               state_in = ST_APPLY;
            end else if (walk_last) begin
               state_in = ST_RESP;
            end else begin
               evt_in = evt_ff + 1'b1;
            end
         end
         ST_APPLY: begin
            if (walk_last) begin
               state_in = ST_RESP;
            end else begin
               evt_in   = evt_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         evt_ff     <= '0;
         pend_ff    <= '0;
         inhibit_ff <= '0;
         id_vld_ff  <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         evt_ff    <= evt_in;
         rsp_valid <= (state_ff == ST_RESP);
         if (csr_valid && csr_ready) begin
            inhibit_ff <= csr_data;
         end
         if (state_ff == ST_IDLE && start) begin
            if (req_payload.cmd == CMD_LOAD_ID) begin
               id_vld_ff[req_payload.index] <= 1'b1;
            end
            if (req_payload.cmd == CMD_SIGNAL) begin
               pend_ff[req_payload.index] <= 1'b1;
            end
         end
         if (state_ff == ST_RESP && req_ff.cmd == CMD_TICK) begin
            pend_ff <= '0;
         end
      end
   end

   // event id memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start && req_payload.cmd == CMD_LOAD_ID) begin
         id_mem[req_payload.index] <= req_payload.value;
      end
      id_rd_ff     <= id_mem[evt_ff];
      id_rd_vld_ff <= id_vld_ff[evt_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_payload;
      end
   end

   // selectors and counters: shared compare applied to all counter lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            sel_ff[k] <= '0;
            cnt_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            if (state_ff == ST_IDLE && start && req_payload.cmd == CMD_WR_SEL
                && req_payload.index == EVT_IDX_W'(k)) begin
               sel_ff[k] <= req_payload.value;
            end
            if (state_ff == ST_APPLY && id_rd_vld_ff && id_rd_ff != '0
                && sel_ff[k] == id_rd_ff
                && !((k + INHIBIT_OFFSET < 32) && inhibit_ff[(k + INHIBIT_OFFSET) % 32])) begin
               cnt_ff[k] <= cnt_ff[k] + 64'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         rd_data_ff <= '0;
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            if (req_payload.cmd == CMD_READ && req_payload.index == EVT_IDX_W'(k)) begin
               rd_data_ff <= cnt_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload.read_data      <= rd_data_ff;
      rsp_payload.pending_events <= (req_ff.cmd == CMD_TICK) ? 64'd0 : pend_ff;
   end

   // result beat is registered in the cycle after the response state
   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> rsp_valid)
      else $error("missing result beat");
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && req_ff.cmd == CMD_TICK) |=> (pend_ff == '0))
      else $error("pending set not cleared by tick");

endmodule
`default_nettype wire
